// ===== rtl/cluster_bitmap_allocator_top_assert.svh =====
// Assertion macros for the cluster bitmap allocator
`ifndef CLUSTER_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define CLUSTER_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset
`define CBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define CBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cba_pkg.sv =====
package cba_pkg;

  localparam int MaxClusters = 65536;
  localparam int WordBits    = 32;
  localparam int MapWords    = MaxClusters / WordBits;
  localparam int WordAw      = $clog2(MapWords);
  localparam int BitAw       = $clog2(WordBits);
  localparam int CntW        = 17;
  localparam int PosW        = 18;

  typedef enum logic [1:0] {
    FUNC_FIND  = 2'd0,
    FUNC_USE   = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_COUNT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_STEP,
    S_CLEAR,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic check;
    logic rd;
    logic step;
    logic clr;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fin;
    logic clr_done;
  } stat_t;

endpackage

// ===== rtl/cluster_bitmap_allocator_top.sv =====
// Channel | Ports                                   | Handshake
// input   | in_func, in_cluster, in_count           | start & !busy
// result  | out_status, out_start_cluster, out_free_count | out_valid, one cycle
// config  | cfg_data                                | cfg_valid & cfg_ready
// Each bitmap bit takes a word read, then a bit step.
// After reset a clearing sweep writes all 2048 words, one per cycle, with busy high.
// Config writes are held off while an item is requested or in flight.
// The result strobe lasts one cycle; the receiver cannot stall it.
module cluster_bitmap_allocator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_func,
  input  logic [cba_pkg::CntW-1:0]  in_cluster,
  input  logic [cba_pkg::CntW-1:0]  in_count,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [cba_pkg::CntW-1:0]  out_start_cluster,
  output logic [cba_pkg::CntW-1:0]  out_free_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cba_pkg::CntW-1:0]  cfg_data
);

  cba_pkg::cmd_t  cmd;
  cba_pkg::stat_t stat;
  logic [cba_pkg::CntW-1:0] cluster_count_r;

  // cluster count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= cba_pkg::CntW'(cba_pkg::MaxClusters);
    end else if (cfg_valid && cfg_ready) begin
      cluster_count_r <= cfg_data;
    end
  end
  // only written while no item is in flight
  assign cfg_ready = !busy && !start;

  cba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd),
    .stat  (stat)
  );

  cba_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_func),
    .in_cluster (in_cluster),
    .in_count   (in_count),
    .cfg_n      (cluster_count_r),
    .res_status (out_status),
    .res_start  (out_start_cluster),
    .res_free   (out_free_count)
  );

endmodule

// ===== rtl/cba_datapath.sv =====
module cba_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cba_pkg::cmd_t             cmd,
  output cba_pkg::stat_t            stat,
  input  logic [1:0]                in_func,
  input  logic [cba_pkg::CntW-1:0]  in_cluster,
  input  logic [cba_pkg::CntW-1:0]  in_count,
  input  logic [cba_pkg::CntW-1:0]  cfg_n,
  output logic [1:0]                res_status,
  output logic [cba_pkg::CntW-1:0]  res_start,
  output logic [cba_pkg::CntW-1:0]  res_free
);

  localparam int W  = cba_pkg::PosW;
  localparam int AW = cba_pkg::WordAw;
  localparam int BW = cba_pkg::BitAw;

  // bitmap memory, registered read
  logic [cba_pkg::WordBits-1:0] mem [cba_pkg::MapWords];
  logic [cba_pkg::WordBits-1:0] rdata_r;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [cba_pkg::WordBits-1:0] wdata;

  logic [1:0]   func_r;
  logic [W-1:0] len_r, n_r, start_r, pos_r, bgn_r, mend_r, used_r;
  logic [1:0]   status_r, status_nxt;
  logic [W-1:0] first_r, first_nxt;
  logic         fin_r, fin_nxt;
  logic [W-1:0] pos_nxt, bgn_nxt, used_nxt;
  logic [AW:0]  clr_r;
  logic         bit_v;
  logic [W-1:0] end_v;
  logic [W-1:0] hint_v, n_v, cl_v, cnt_v;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[pos_r[BW+AW-1:BW]];
  end

  assign bit_v = rdata_r[pos_r[BW-1:0]];
  assign end_v = pos_r + W'(1);
  assign n_v   = (W'(cfg_n) > W'(cba_pkg::MaxClusters)) ? W'(cba_pkg::MaxClusters) : W'(cfg_n);
  assign cl_v  = W'(in_cluster);
  assign cnt_v = W'(in_count);
  assign hint_v = (cl_v < W'(2) || (cl_v - W'(2)) >= n_v) ? '0 : cl_v - W'(2);

  // write port: clearing sweep or a single bit flip while marking
  always_comb begin
    we    = 1'b0;
    waddr = pos_r[BW+AW-1:BW];
    wdata = rdata_r ^ (cba_pkg::WordBits'(1) << pos_r[BW-1:0]);
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_r[AW-1:0];
      wdata = '0;
    end else if (cmd.step && !fin_r &&
                 (func_r == cba_pkg::FUNC_USE || func_r == cba_pkg::FUNC_FREE) &&
                 (bit_v != (func_r == cba_pkg::FUNC_USE))) begin
      we = 1'b1;
    end
  end

  // one bit per step; mark walks flip the bit before moving on
  always_comb begin
    status_nxt = status_r;
    first_nxt  = first_r;
    fin_nxt    = fin_r;
    pos_nxt    = pos_r;
    bgn_nxt    = bgn_r;
    used_nxt   = used_r;
    if (cmd.check) begin
      fin_nxt = 1'b1;
      unique case (func_r)
        cba_pkg::FUNC_FIND: begin
          if (len_r == '0) status_nxt = cba_pkg::ST_ERROR;
          else if (n_r == '0) status_nxt = cba_pkg::ST_NOSPACE;
          else fin_nxt = 1'b0;
        end
        cba_pkg::FUNC_USE, cba_pkg::FUNC_FREE: begin
          if (len_r == '0 || start_r == '1 || mend_r > n_r) status_nxt = cba_pkg::ST_ERROR;
          else fin_nxt = 1'b0;
        end
        default: begin
          if (n_r == '0) first_nxt = '0;
          else fin_nxt = 1'b0;
        end
      endcase
    end else if (cmd.step && !fin_r) begin
      unique case (func_r)
        cba_pkg::FUNC_FIND: begin
          pos_nxt = end_v;
          if (bit_v) begin
            bgn_nxt = end_v;
          end else if (end_v - bgn_r == len_r) begin
            fin_nxt = 1'b1;
            first_nxt = bgn_r + W'(2);
          end
          if (!(!bit_v && end_v - bgn_r == len_r)) begin
            if (end_v == start_r) begin
              fin_nxt = 1'b1;
              status_nxt = cba_pkg::ST_NOSPACE;
            end else if (end_v >= n_r) begin
              pos_nxt = '0;
              bgn_nxt = '0;
              if (start_r == '0) begin
                fin_nxt = 1'b1;
                status_nxt = cba_pkg::ST_NOSPACE;
              end
            end
          end
        end
        cba_pkg::FUNC_USE, cba_pkg::FUNC_FREE: begin
          if (bit_v == (func_r == cba_pkg::FUNC_USE)) begin
            fin_nxt = 1'b1;
            status_nxt = cba_pkg::ST_ERROR;
          end else begin
            pos_nxt = end_v;
            if (end_v == mend_r) fin_nxt = 1'b1;
          end
        end
        default: begin
          used_nxt = used_r + W'(bit_v);
          pos_nxt  = end_v;
          if (end_v == n_r) begin
            fin_nxt = 1'b1;
            first_nxt = n_r - used_r - W'(bit_v);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      fin_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + (AW+1)'(1);
      fin_r <= cmd.load ? 1'b0 : fin_nxt;
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      len_r    <= cnt_v;
      n_r      <= n_v;
      status_r <= cba_pkg::ST_OK;
      first_r  <= '0;
      used_r   <= '0;
      if (in_func == cba_pkg::FUNC_FIND) begin
        start_r <= hint_v;
        pos_r   <= hint_v;
        bgn_r   <= hint_v;
      end else if (in_func == cba_pkg::FUNC_COUNT) begin
        start_r <= '0;
        pos_r   <= '0;
        bgn_r   <= '0;
      end else begin
        // all ones flags a first cluster below 2
        start_r <= (cl_v < W'(2)) ? '1 : cl_v - W'(2);
        pos_r   <= cl_v - W'(2);
        bgn_r   <= '0;
      end
      mend_r <= cl_v - W'(2) + cnt_v;
    end else begin
      status_r <= status_nxt;
      first_r  <= first_nxt;
      pos_r    <= pos_nxt;
      bgn_r    <= bgn_nxt;
      used_r   <= used_nxt;
    end
  end

  assign stat.fin      = fin_r;
  assign stat.clr_done = clr_r[AW];
  assign res_status    = status_r;
  assign res_start     = (func_r == cba_pkg::FUNC_FIND) ? first_r[cba_pkg::CntW-1:0] : '0;
  assign res_free      = (func_r == cba_pkg::FUNC_COUNT) ? first_r[cba_pkg::CntW-1:0] : '0;

endmodule

// ===== rtl/cba_ctrl.sv =====
module cba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output cba_pkg::cmd_t  cmd,
  input  cba_pkg::stat_t stat
);

  cba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cba_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // READ fetches the word, STEP consumes one bit
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    done      = 1'b0;
    unique case (state_r)
      cba_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = cba_pkg::S_CHECK;
        end
      end
      cba_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = cba_pkg::S_READ;
      end
      cba_pkg::S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = stat.fin ? cba_pkg::S_DONE : cba_pkg::S_STEP;
      end
      cba_pkg::S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = cba_pkg::S_READ;
      end
      cba_pkg::S_CLEAR: begin
        if (stat.clr_done) state_nxt = cba_pkg::S_IDLE;
        else cmd.clr = 1'b1;
      end
      cba_pkg::S_DONE: begin
        done      = 1'b1;
        state_nxt = cba_pkg::S_IDLE;
      end
      default: state_nxt = cba_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/cba_checker.sv =====
`include "cluster_bitmap_allocator_top_assert.svh"
module cba_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [1:0]               out_status,
  input logic [cba_pkg::CntW-1:0] out_start_cluster,
  input logic [cba_pkg::CntW-1:0] out_free_count
);
  // accepted item keeps the block busy next cycle
  `CBA_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "not busy after start")
  // result only while busy and then released
  `CBA_ASSERT_NXT(a_idle_after_done, clk, rst_n, out_valid, !busy, "busy after result")
  `CBA_ASSERT_IMP(a_done_busy, clk, rst_n, out_valid, busy, "result while idle")
  // a found run reports OK status and a zero free count
  `CBA_ASSERT_IMP(a_start_ok, clk, rst_n, out_valid && out_start_cluster != '0,
                  out_status == cba_pkg::ST_OK && out_free_count == '0, "bad find result")
endmodule

bind cluster_bitmap_allocator_top cba_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_start_cluster (out_start_cluster),
  .out_free_count    (out_free_count)
);

// ===== tb/sv/tb.sv =====
module tb;
  import cba_pkg::*;

  // Bus handles
  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_func;
  logic [CntW-1:0]  in_cluster;
  logic [CntW-1:0]  in_count;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [CntW-1:0]  out_start_cluster;
  logic [CntW-1:0]  out_free_count;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CntW-1:0]  cfg_data;

  localparam int CycleLimit = 4000000;

  typedef struct {
    status_t         status;
    logic [CntW-1:0] start_cluster;
    logic [CntW-1:0] free_count;
  } alloc_reply_t;

  typedef struct {
    func_t           func;
    logic [CntW-1:0] cluster;
    logic [CntW-1:0] count;
    bit              typed;
    status_t         status;
    logic [CntW-1:0] start_cluster;
    logic [CntW-1:0] free_count;
  } alloc_row_t;

  // Shadow copy of the allocation bitmap and the cluster count register
  bit          used_map [0:MaxClusters-1];
  int unsigned shadow_clusters;

  alloc_reply_t reply_q[$];
  int unsigned  n_errors;
  int unsigned  n_checked;
  int unsigned  n_sent;
  int unsigned  n_finds_ok;
  int unsigned  cycles;
  int unsigned  burst_left;

  cluster_bitmap_allocator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_cluster(in_cluster), .in_count(in_count),
    .out_valid(out_valid), .out_status(out_status),
    .out_start_cluster(out_start_cluster), .out_free_count(out_free_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned live_clusters();
    return (shadow_clusters > MaxClusters) ? MaxClusters : shadow_clusters;
  endfunction

  function automatic bit map_bit(int unsigned p);
    if (p >= MaxClusters) return 1'b0;
    return used_map[p];
  endfunction

  // First-fit free-run search, wraps once and never spans the wrap
  function automatic alloc_reply_t search_free_run(int unsigned hint, int unsigned len);
    alloc_reply_t r;
    int unsigned n, s, e, b, p;
    n = live_clusters();
    r.status = ST_OK;
    r.start_cluster = '0;
    r.free_count = '0;
    if (len == 0) begin
      r.status = ST_ERROR;
      return r;
    end
    if (n == 0) begin
      r.status = ST_NOSPACE;
      return r;
    end
    s = (hint < 2 || hint - 2 >= n) ? 0 : hint - 2;
    e = s;
    b = s;
    forever begin
      p = e;
      e++;
      if (!map_bit(p)) begin
        if (e - b == len) begin
          r.start_cluster = CntW'(b + 2);
          return r;
        end
      end else begin
        b = e;
      end
      if (e == s) begin
        r.status = ST_NOSPACE;
        return r;
      end
      if (e >= n) begin
        e = 0;
        b = 0;
        if (s == 0) begin
          r.status = ST_NOSPACE;
          return r;
        end
      end
    end
  endfunction

  // Range mark; a conflict stops the walk and keeps earlier flips
  function automatic alloc_reply_t mark_range(int unsigned first, int unsigned len, bit to_used);
    alloc_reply_t r;
    int unsigned n, p, k;
    n = live_clusters();
    r.status = ST_OK;
    r.start_cluster = '0;
    r.free_count = '0;
    if (len == 0 || first < 2 || first - 2 + len > n) begin
      r.status = ST_ERROR;
      return r;
    end
    p = first - 2;
    for (k = 0; k < len; k++) begin
      if (map_bit(p) == to_used) begin
        r.status = ST_ERROR;
        return r;
      end
      used_map[p] = to_used;
      p++;
    end
    return r;
  endfunction

  function automatic alloc_reply_t tally_free();
    alloc_reply_t r;
    int unsigned n, p, u;
    n = live_clusters();
    u = 0;
    for (p = 0; p < n; p++) if (used_map[p]) u++;
    r.status = ST_OK;
    r.start_cluster = '0;
    r.free_count = CntW'(n - u);
    return r;
  endfunction

  function automatic alloc_reply_t predict_alloc(func_t f, int unsigned cl, int unsigned cnt);
    case (f)
      FUNC_FIND:  return search_free_run(cl, cnt);
      FUNC_USE:   return mark_range(cl, cnt, 1'b1);
      FUNC_FREE:  return mark_range(cl, cnt, 1'b0);
      default:    return tally_free();
    endcase
  endfunction

  // Drive one item and wait for acceptance; bursts keep start high
  task automatic issue_item(alloc_row_t row, output alloc_reply_t got);
    alloc_reply_t r;
    int gap;
    if (burst_left == 0) begin
      start = 1'b0;
      gap = $urandom_range(0, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_func = row.func;
    in_cluster = row.cluster;
    in_count = row.count;
    start = 1'b1;
    do @(posedge clk); while (busy);
    r = predict_alloc(row.func, row.cluster, row.count);
    if (row.typed) begin
      r.status = row.status;
      r.start_cluster = row.start_cluster;
      r.free_count = row.free_count;
    end
    if (r.status == ST_OK && row.func == FUNC_FIND) n_finds_ok++;
    reply_q.push_back(r);
    n_sent++;
    burst_left--;
    got = r;
    @(negedge clk);
    if (burst_left == 0) start = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    burst_left = 0;
    while (reply_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic set_clusters(int unsigned v);
    drain();
    cfg_data = CntW'(v);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_clusters = v & 32'h1FFFF;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic alloc_row_t mk(func_t f, int unsigned cl, int unsigned cnt);
    alloc_row_t row;
    row.func = f;
    row.cluster = CntW'(cl);
    row.count = CntW'(cnt);
    row.typed = 1'b0;
    row.status = ST_OK;
    row.start_cluster = '0;
    row.free_count = '0;
    return row;
  endfunction

  function automatic alloc_row_t mk_exp(func_t f, int unsigned cl, int unsigned cnt,
                                        status_t st, int unsigned sc, int unsigned fc);
    alloc_row_t row;
    row = mk(f, cl, cnt);
    row.typed = 1'b1;
    row.status = st;
    row.start_cluster = CntW'(sc);
    row.free_count = CntW'(fc);
    return row;
  endfunction

  // Result checker
  always @(posedge clk) begin
    alloc_reply_t w;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: status %0d", out_status);
      end else begin
        w = reply_q.pop_front();
        n_checked++;
        if (out_status !== w.status || out_start_cluster !== w.start_cluster ||
            out_free_count !== w.free_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp st %0d sc %0d fc %0d, got st %0d sc %0d fc %0d",
                     w.status, w.start_cluster, w.free_count,
                     out_status, out_start_cluster, out_free_count);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL cluster_bitmap_allocator_top");
      $finish;
    end
  end

  initial begin
    alloc_row_t   rows[$];
    alloc_reply_t got;
    alloc_row_t   row;
    int unsigned  sizes[$];
    int unsigned  n, k, i, sel, cl, cnt, last_cl, last_cnt;
    bit           have_run;

    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_FIND;
    in_cluster = '0;
    in_count = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    n_finds_ok = 0;
    cycles = 0;
    burst_left = 0;
    shadow_clusters = 65536;
    for (i = 0; i < MaxClusters; i++) used_map[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the full-size bitmap
    rows.push_back(mk_exp(FUNC_COUNT, 0, 0, ST_OK, 0, 65536));
    rows.push_back(mk_exp(FUNC_FIND, 0, 0, ST_ERROR, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 0, 1, ST_ERROR, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 2, 0, ST_ERROR, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 65537, 1, ST_OK, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 65537, 1, ST_ERROR, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 65537, 2, ST_ERROR, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 2, 4, ST_OK, 0, 0));
    rows.push_back(mk_exp(FUNC_USE, 4, 4, ST_ERROR, 0, 0));
    rows.push_back(mk(FUNC_FREE, 3, 3));
    rows.push_back(mk(FUNC_FIND, 0, 3));
    rows.push_back(mk(FUNC_FIND, 131071, 1));
    rows.push_back(mk(FUNC_FIND, 65537, 1));
    rows.push_back(mk_exp(FUNC_FREE, 65537, 1, ST_OK, 0, 0));
    rows.push_back(mk(FUNC_FREE, 2, 65536));
    rows.push_back(mk(FUNC_USE, 1, 131071));
    rows.push_back(mk(FUNC_COUNT, 0, 0));
    foreach (rows[j]) issue_item(rows[j], got);

    // Register above the maximum saturates
    set_clusters(131071);
    issue_item(mk(FUNC_COUNT, 0, 0), got);
    issue_item(mk(FUNC_FIND, 3, 65536), got);

    // Zero cluster count
    set_clusters(0);
    issue_item(mk_exp(FUNC_FIND, 5, 1, ST_NOSPACE, 0, 0), got);
    issue_item(mk_exp(FUNC_USE, 2, 1, ST_ERROR, 0, 0), got);
    issue_item(mk_exp(FUNC_COUNT, 0, 0, ST_OK, 0, 0), got);
    issue_item(mk_exp(FUNC_FIND, 2, 0, ST_ERROR, 0, 0), got);

    // Start from an empty map for the random part
    set_clusters(65536);
    issue_item(mk(FUNC_FREE, 2, 1), got);

    // Random phases over small cluster counts
    sizes = '{1, 33, 64, 150, 300, 97, 2, 211};
    foreach (sizes[z]) begin
      set_clusters(sizes[z]);
      n = sizes[z];
      have_run = 1'b0;
      for (k = 0; k < 33; k++) begin
        sel = $urandom_range(0, 99);
        if (have_run && sel < 45) begin
          // claim the run just found
          row = mk(FUNC_USE, last_cl, last_cnt);
          have_run = 1'b0;
        end else if (sel < 60) begin
          cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : $urandom_range(1, 6);
          cl = ($urandom_range(0, 7) == 0) ? ($urandom() & 32'h1FFFF) : $urandom_range(2, n + 1);
          row = mk(FUNC_FIND, cl, cnt);
        end else if (sel < 85) begin
          cl = $urandom_range(2, n + 1);
          cnt = $urandom_range(1, 5);
          row = mk(FUNC_FREE, cl, cnt);
        end else if (sel < 93) begin
          row = mk(func_t'($urandom_range(0, 2)), $urandom() & 32'h1FFFF,
                   ($urandom_range(0, 3) == 0) ? ($urandom() & 32'h1FFFF) : $urandom_range(0, 3));
        end else begin
          row = mk(FUNC_COUNT, $urandom() & 32'h1FFFF, $urandom() & 32'h1FFFF);
        end
        issue_item(row, got);
        if (row.func == FUNC_FIND && got.status == ST_OK) begin
          have_run = 1'b1;
          last_cl = got.start_cluster;
          last_cnt = row.count;
        end
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("sent %0d items, checked %0d results, %0d successful finds",
             n_sent, n_checked, n_finds_ok);
    $display("cluster counts from 0 to saturated, %0d mismatches", n_errors);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("PASS cluster_bitmap_allocator_top");
    end else begin
      $display("FAIL cluster_bitmap_allocator_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cba_pkg.sv
rtl/cba_datapath.sv
rtl/cba_ctrl.sv
rtl/cluster_bitmap_allocator_top.sv
rtl/cba_checker.sv
tb/sv/tb.sv
